[rtl/mbps_pkg.sv]
package mbps_pkg;

  // Store sizes and pattern limit
  localparam int RAM_SIZE    = 4194304;
  localparam int ROM_SIZE    = 262144;
  localparam int PATTERN_MAX = 8;

  localparam int RAM_AW = $clog2(RAM_SIZE);
  localparam int ROM_AW = $clog2(ROM_SIZE);
  localparam int PAT_IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

  // Bus address width and scan address width (sign bit plus 25 magnitude bits)
  localparam int ADDR_W = 24;
  localparam int AD_W   = 26;

  // Item opcodes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_RAM_TOP  = 2'd0;
  localparam logic [1:0] REG_ROM_BASE = 2'd1;
  localparam logic [1:0] REG_ROM_END  = 2'd2;

  localparam logic [24:0] RAM_TOP_RST  = 25'h0400000;
  localparam logic [23:0] ROM_BASE_RST = 24'hE00000;
  localparam logic [24:0] ROM_END_RST  = 25'h0E40000;

  typedef struct packed {
    logic        op;
    logic [23:0] address;
    logic [7:0]  data_byte;
    logic [63:0] pattern_bytes;
    logic [3:0]  pattern_length;
    logic        search_down;
    logic        word_only;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [23:0] match_address;
  } out_item_t;

  typedef struct packed {
    logic [24:0] ram_top;
    logic [23:0] rom_base;
    logic [24:0] rom_end;
  } cfg_regs_t;

  typedef struct packed {
    logic load;       // latch search item
    logic mem_wr;     // store a write item
    logic jump;       // hop over the RAM/ROM hole
    logic advance;    // step scan address by one
    logic issue;      // start compare at scan address
    logic rd;         // read both stores at current pointer
    logic next_byte;  // move to next pattern byte
    logic hit;        // pattern matched
    logic out_load;   // load result register
  } dp_cmd_t;

  typedef struct packed {
    logic len_zero;
    logic end_hit;
    logic skip;
    logic byte_eq;
    logic last;
  } dp_sts_t;

endpackage

[rtl/mbps_ctrl.sv]
module mbps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  mbps_pkg::dp_sts_t sts,
  output mbps_pkg::dp_cmd_t cmd
);
  import mbps_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_JUMP = 3'd1;
  localparam logic [2:0] ST_TEST = 3'd2;
  localparam logic [2:0] ST_READ = 3'd3;
  localparam logic [2:0] ST_CMP  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_SEARCH) begin
            cmd.load  = 1'b1;
            state_nxt = ST_JUMP;
          end else begin
            cmd.mem_wr = 1'b1;
          end
        end
      end
      ST_JUMP: begin
        if (sts.len_zero) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.jump  = 1'b1;
          state_nxt = ST_TEST;
        end
      end
      ST_TEST: begin
        if (sts.end_hit) begin
          state_nxt = ST_FIN;
        end else if (sts.skip) begin
          cmd.advance = 1'b1;
          state_nxt   = ST_JUMP;
        end else begin
          cmd.issue = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (sts.byte_eq && sts.last) begin
          cmd.hit   = 1'b1;
          state_nxt = ST_FIN;
        end else if (sts.byte_eq) begin
          cmd.next_byte = 1'b1;
          state_nxt     = ST_READ;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = ST_JUMP;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/mbps_dp.sv]
module mbps_dp (
  input  logic                clk,
  input  mbps_pkg::in_item_t  in_data,
  input  mbps_pkg::cfg_regs_t cfg,
  input  mbps_pkg::dp_cmd_t   cmd,
  output mbps_pkg::dp_sts_t   sts,
  output mbps_pkg::out_item_t res
);
  import mbps_pkg::*;

  logic [7:0] ram_mem [RAM_SIZE];
  logic [7:0] rom_mem [ROM_SIZE];

  logic signed [AD_W-1:0] ad_r, ad_nxt;
  logic [7:0]        pat_r [PATTERN_MAX];
  logic [3:0]        len_r;
  logic              dir_r;
  logic              word_r;
  logic              found_r;
  logic              in_rom_r;
  logic [PAT_IW-1:0] k_r;
  logic [24:0]       ptr_r;
  logic [24:0]       rom_off_r;
  logic [7:0]        ram_q_r, rom_q_r;
  logic              ram_ok_r, rom_ok_r;
  out_item_t         res_r;

  logic signed [AD_W-1:0] ram_top_s, rom_base_s, rom_end_s;
  logic signed [AD_W-1:0] ad_len, step;
  logic       in_hole, in_ram, fit;
  logic [3:0] len_in;
  logic [7:0] cur_byte;

  // write decode
  logic [24:0] wr_a;
  logic [23:0] wr_off;
  logic        ram_we, rom_we;

  assign ram_top_s  = signed'({1'b0, cfg.ram_top});
  assign rom_base_s = signed'({2'b00, cfg.rom_base});
  assign rom_end_s  = signed'({1'b0, cfg.rom_end});

  assign wr_a   = {1'b0, in_data.address};
  assign wr_off = in_data.address - cfg.rom_base;
  assign ram_we = cmd.mem_wr && (wr_a < cfg.ram_top) && (wr_a < 25'(RAM_SIZE));
  assign rom_we = cmd.mem_wr && !(wr_a < cfg.ram_top) &&
                  (in_data.address >= cfg.rom_base) && (wr_a < cfg.rom_end) &&
                  ({1'b0, wr_off} < 25'(ROM_SIZE));

  // scan address
  assign in_hole = (ad_r >= ram_top_s) && (ad_r < rom_base_s);
  assign step    = dir_r ? signed'({AD_W{1'b1}}) : signed'(AD_W'(1));

  always_comb begin
    ad_nxt = ad_r;
    if (cmd.load) begin
      ad_nxt = signed'({2'b00, in_data.address});
    end else if (cmd.jump && in_hole) begin
      ad_nxt = dir_r ? (ram_top_s - signed'(AD_W'(1))) : rom_base_s;
    end else if (cmd.advance) begin
      ad_nxt = ad_r + step;
    end
  end

  // candidate checks
  assign in_ram = ad_r < ram_top_s;
  assign ad_len = ad_r + signed'({{(AD_W-4){1'b0}}, len_r});
  assign fit    = in_ram ? (ad_len <= ram_top_s) : (ad_len <= rom_end_s);

  assign sts.len_zero = (len_r == 4'd0);
  assign sts.end_hit  = ad_r[AD_W-1] || ad_r[AD_W-2] || (ad_r >= rom_end_s);
  assign sts.skip     = (ad_r[0] && word_r) || !fit;

  // out-of-range locations read as zero
  assign cur_byte    = in_rom_r ? (rom_ok_r ? rom_q_r : 8'd0) : (ram_ok_r ? ram_q_r : 8'd0);
  assign sts.byte_eq = (cur_byte == pat_r[k_r]);
  assign sts.last    = (4'(k_r) == (len_r - 4'd1));

  assign len_in = (in_data.pattern_length > 4'(PATTERN_MAX)) ? 4'(PATTERN_MAX)
                                                             : in_data.pattern_length;

  always_ff @(posedge clk) begin
    ad_r <= ad_nxt;
    if (cmd.load) begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
        pat_r[i] <= in_data.pattern_bytes[8*i +: 8];
      end
      len_r   <= len_in;
      dir_r   <= in_data.search_down;
      word_r  <= in_data.word_only;
      found_r <= 1'b0;
    end
    if (cmd.hit) begin
      found_r <= 1'b1;
    end
    if (cmd.issue) begin
      in_rom_r  <= !in_ram;
      k_r       <= '0;
      ptr_r     <= ad_r[24:0];
      rom_off_r <= ad_r[24:0] - {1'b0, cfg.rom_base};
    end else if (cmd.next_byte) begin
      k_r       <= k_r + PAT_IW'(1);
      ptr_r     <= ptr_r + 25'd1;
      rom_off_r <= rom_off_r + 25'd1;
    end
    if (cmd.rd) begin
      ram_ok_r <= ptr_r < 25'(RAM_SIZE);
      rom_ok_r <= rom_off_r < 25'(ROM_SIZE);
    end
    if (cmd.out_load) begin
      res_r.found         <= found_r;
      res_r.match_address <= found_r ? ad_r[23:0] : 24'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      ram_mem[in_data.address[RAM_AW-1:0]] <= in_data.data_byte;
    end
    if (cmd.rd) begin
      ram_q_r <= ram_mem[ptr_r[RAM_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rom_we) begin
      rom_mem[wr_off[ROM_AW-1:0]] <= in_data.data_byte;
    end
    if (cmd.rd) begin
      rom_q_r <= rom_mem[rom_off_r[ROM_AW-1:0]];
    end
  end

  assign res = res_r;

endmodule

[rtl/memory_byte_pattern_search.sv]
// Channel  | Ports                                   | Moves
// ---------+-----------------------------------------+-------------------------------
// input    | in_valid, in_ready, in_data             | write or search item
// result   | out_valid, out_ready, out_data          | found flag and match address
// config   | cfg_psel/penable/pwrite/paddr/pwdata,   | ram_top, rom_base, rom_end
//          | cfg_prdata, cfg_pready                  | at byte addresses 0, 4, 8
//
// Writes can stream back to back. A search is accepted, then passes over each start
// address (hole hop, then bounds/alignment/fit test), compares each pattern byte
// (registered store read, then compare) and finally loads the result. Reset clears the
// controller and presets the config registers; the byte stores are not cleared.
// A result stalled by out_ready does not block input transfers; only the next search's
// result waits for it in the final state.
module memory_byte_pattern_search (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mbps_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mbps_pkg::out_item_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [3:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import mbps_pkg::*;

  cfg_regs_t cfg_r;
  dp_cmd_t   cmd;
  dp_sts_t   sts;
  logic      cfg_we;

  // Config port: zero-wait, write lands on the access phase
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ram_top  <= RAM_TOP_RST;
      cfg_r.rom_base <= ROM_BASE_RST;
      cfg_r.rom_end  <= ROM_END_RST;
    end else if (cfg_we) begin
      case (cfg_paddr[3:2])
        REG_RAM_TOP:  cfg_r.ram_top  <= cfg_pwdata[24:0];
        REG_ROM_BASE: cfg_r.rom_base <= cfg_pwdata[23:0];
        REG_ROM_END:  cfg_r.rom_end  <= cfg_pwdata[24:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_RAM_TOP:  cfg_prdata = {7'd0, cfg_r.ram_top};
      REG_ROM_BASE: cfg_prdata = {8'd0, cfg_r.rom_base};
      REG_ROM_END:  cfg_prdata = {7'd0, cfg_r.rom_end};
      default:      cfg_prdata = 32'd0;
    endcase
  end

  // Sequencer: idle/accept, hole hop, candidate test, read, compare, result
  mbps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.op),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Byte stores, scan address, pattern, compare and result register
  mbps_dp u_dp (
    .clk     (clk),
    .in_data (in_data),
    .cfg     (cfg_r),
    .cmd     (cmd),
    .sts     (sts),
    .res     (out_data)
  );

  // A search transfer makes the block busy on the next cycle
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.op == OP_SEARCH) |=> !in_ready)
    else $error("input still ready after search transfer");

  // A write transfer never raises a result
  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.op == OP_WRITE) && !out_valid |=> !out_valid)
    else $error("result raised by a write item");

  // Miss reports address zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> (out_data.match_address == 24'd0))
    else $error("nonzero address on a miss");

  // Result leaves only through the handshake
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

endmodule

[dv/tb.sv]
module tb;
  import mbps_pkg::*;

  localparam longint ADDR_MAX    = 64'hFFFFFF;
  localparam int     SCAN_BUDGET = 300;    // start addresses a random search may visit
  localparam int     STALL_LIMIT = 20000;  // cycles with no transfer before giving up

  // Shadow of the byte stores and config, plus the queue of pending search answers.
  class search_scoreboard;
    bit [7:0]  ram_mem[int];
    bit [7:0]  rom_mem[int];
    longint    ram_top;
    longint    rom_base;
    longint    rom_end;
    out_item_t expected_q[$];
    int        errors;
    bit        stale_read;

    function new();
      ram_top  = RAM_TOP_RST;
      rom_base = ROM_BASE_RST;
      rom_end  = ROM_END_RST;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_RAM_TOP:  ram_top  = value[24:0];
        REG_ROM_BASE: rom_base = value[23:0];
        REG_ROM_END:  rom_end  = value[24:0];
        default: ;
      endcase
    endfunction

    // Byte as the block sees it; store slots past the physical size read as zero.
    function bit [7:0] read_byte(longint a);
      longint off;
      if (a < ram_top) begin
        if (a >= RAM_SIZE) return 8'h00;
        if (!ram_mem.exists(int'(a))) begin
          stale_read = 1'b1;
          return 8'h00;
        end
        return ram_mem[int'(a)];
      end
      off = a - rom_base;
      if (off < 0 || off >= ROM_SIZE) return 8'h00;
      if (!rom_mem.exists(int'(off))) begin
        stale_read = 1'b1;
        return 8'h00;
      end
      return rom_mem[int'(off)];
    endfunction

    // Walks memory like the block does. bad flags a walk that touches a
    // never-written byte or visits more than max_visits start addresses.
    function out_item_t scan(in_item_t it, int max_visits, output bit bad);
      out_item_t res;
      longint    ad;
      longint    limit;
      int        len;
      int        k;
      int        visits;
      bit        hit;
      ad         = it.address;
      len        = it.pattern_length;
      visits     = 0;
      hit        = 1'b0;
      bad        = 1'b0;
      stale_read = 1'b0;
      if (len > PATTERN_MAX) len = PATTERN_MAX;
      if (len > 0) begin
        while (1) begin
          if (ad >= ram_top && ad < rom_base) ad = it.search_down ? ram_top - 1 : rom_base;
          if (ad < 0 || ad >= rom_end || ad > ADDR_MAX) break;
          visits++;
          if (visits > max_visits) begin
            bad = 1'b1;
            break;
          end
          if (!(ad[0] && it.word_only)) begin
            k     = -1;
            limit = (ad < ram_top) ? ram_top : rom_end;
            if (read_byte(ad) == it.pattern_bytes[7:0] && ad + len <= limit) begin
              for (k = 1; k < len; k++)
                if (read_byte(ad + k) != it.pattern_bytes[8*k +: 8]) break;
            end
            if (k >= len) begin
              hit = 1'b1;
              break;
            end
          end
          ad += it.search_down ? -1 : 1;
        end
      end
      bad               = bad | stale_read;
      res.found         = hit;
      res.match_address = hit ? ad[23:0] : 24'h0;
      return res;
    endfunction

    function void note_input(in_item_t it);
      longint a;
      bit     bad;
      a = it.address;
      if (it.op == OP_WRITE) begin
        if (a < ram_top) begin
          if (a < RAM_SIZE) ram_mem[int'(a)] = it.data_byte;
        end else if (a >= rom_base && a < rom_end) begin
          if (a - rom_base < ROM_SIZE) rom_mem[int'(a - rom_base)] = it.data_byte;
        end
      end else begin
        expected_q.push_back(scan(it, 32'h7fffffff, bad));
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result: found %0b match_address %06h", got.found, got.match_address);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.found !== want.found) begin
        $error("found: expected %0b, actual %0b", want.found, got.found);
        errors++;
      end
      if (got.match_address !== want.match_address) begin
        $error("match_address: expected %06h, actual %06h", want.match_address,
               got.match_address);
        errors++;
      end
    endfunction
  endclass

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  in_item_t    in_data     = '0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  out_item_t   out_data;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  search_scoreboard sb = new();

  bit     idle_enabled = 1'b1;  // cleared for the closing phase: full rate on both sides
  bit     burst_on     = 1'b1;  // re-rolled every 32 transfers to leave gap-free stretches
  int     item_count   = 0;
  int     ready_hold   = 0;
  int     quiet_cycles = 0;
  longint win_lo[2];           // address windows random items focus on
  longint win_hi[2];

  memory_byte_pattern_search i_dut (.*);

  always #5 clk = ~clk;

  // Result side: random back-pressure bursts.
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
      out_ready  <= (ready_hold == 1);
    end else if (idle_enabled && burst_on && $urandom_range(0, 7) == 0) begin
      ready_hold <= $urandom_range(1, 6);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result monitor: every result transfer is checked against the oldest pending answer.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Watchdog: any transfer on any port restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("memory_byte_pattern_search regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One input transfer, with an optional idle burst ahead of it. in_valid stays
  // high across back-to-back transfers.
  task automatic transfer_item(in_item_t it);
    if (idle_enabled && burst_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    item_count++;
    if (item_count % 32 == 0) burst_on = ($urandom_range(0, 3) != 0);
  endtask

  task automatic send_write(longint a, logic [7:0] d);
    in_item_t it;
    it.op             = OP_WRITE;
    it.address        = 24'(a);
    it.data_byte      = d;
    it.pattern_bytes  = {$urandom, $urandom};
    it.pattern_length = 4'($urandom_range(0, 15));
    it.search_down    = 1'($urandom_range(0, 1));
    it.word_only      = 1'($urandom_range(0, 1));
    transfer_item(it);
  endtask

  task automatic send_search(longint a, logic [63:0] pat, int len, bit down, bit word);
    in_item_t it;
    it.op             = OP_SEARCH;
    it.address        = 24'(a);
    it.data_byte      = 8'($urandom);
    it.pattern_bytes  = pat;
    it.pattern_length = 4'(len);
    it.search_down    = down;
    it.word_only      = word;
    transfer_item(it);
  endtask

  // Random content skewed to a few small values so first-byte hits are common.
  task automatic fill(longint lo, longint hi);
    for (longint a = lo; a < hi; a++)
      send_write(a, ($urandom_range(0, 1) != 0) ? 8'($urandom) : 8'($urandom_range(0, 3)));
  endtask

  // Stop feeding until every pending answer is out, then let a trailing write commit.
  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; register loads on the access edge.
  task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_reg(idx, value);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(longint rt, longint rb, longint re);
    wait_results_done();
    cfg_write(REG_RAM_TOP, 32'(rt));
    cfg_write(REG_ROM_BASE, 32'(rb));
    cfg_write(REG_ROM_END, 32'(re));
  endtask

  task automatic set_windows(longint lo0, longint hi0, longint lo1, longint hi1);
    win_lo[0] = lo0;
    win_hi[0] = hi0;
    win_lo[1] = lo1;
    win_hi[1] = hi1;
  endtask

  function automatic longint focus_addr();
    int w;
    w = $urandom_range(0, 1);
    return win_lo[w] + $urandom_range(0, 32'(win_hi[w] - win_lo[w]));
  endfunction

  // Eight bytes lifted from memory, sometimes with one bit flipped: near misses.
  function automatic logic [63:0] memory_run(longint a);
    logic [63:0] pat;
    int          flip;
    for (int k = 0; k < 8; k++) pat[8*k +: 8] = sb.read_byte(a + k);
    if ($urandom_range(0, 3) == 0) begin
      flip      = $urandom_range(0, 63);
      pat[flip] = ~pat[flip];
    end
    return pat;
  endfunction

  // Random mix: writes (mostly into the regions), searches with patterns mostly
  // taken from memory. A search candidate that would read a never-written byte or
  // walk too far is redrawn; after enough misses it falls back to a zero-length
  // search, which touches no memory.
  task automatic random_items(int n);
    in_item_t it;
    bit       bad;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 59) == 0) wait_results_done();
      it.data_byte      = 8'($urandom);
      it.pattern_bytes  = {$urandom, $urandom};
      it.pattern_length = 4'($urandom_range(0, 15));
      it.search_down    = 1'($urandom_range(0, 1));
      it.word_only      = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) < 3) begin
        it.op      = OP_WRITE;
        it.address = ($urandom_range(0, 9) < 7) ? 24'(focus_addr()) : 24'($urandom);
      end else begin
        it.op = OP_SEARCH;
        bad   = 1'b1;
        for (int tries = 0; tries < 40 && bad; tries++) begin
          it.address = ($urandom_range(0, 4) != 0) ? 24'(focus_addr()) : 24'($urandom);
          if ($urandom_range(0, 9) < 7) it.pattern_bytes = memory_run(focus_addr());
          else it.pattern_bytes = {$urandom, $urandom};
          it.pattern_length = ($urandom_range(0, 5) != 0) ? 4'($urandom_range(1, 8))
                                                          : 4'($urandom_range(0, 15));
          it.search_down    = 1'($urandom_range(0, 1));
          it.word_only      = 1'($urandom_range(0, 1));
          void'(sb.scan(it, SCAN_BUDGET, bad));
        end
        if (bad) it.pattern_length = '0;
      end
      transfer_item(it);
    end
  endtask

  initial begin
    longint rb_far;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Small RAM and ROM with a hole between; every byte in both regions written.
    set_config(64, 128, 160);
    fill(0, 64);
    fill(128, 160);

    // Directed: field extremes, ignored writes, hole hops, region fit.
    send_write(0, 8'hFF);
    send_write(63, 8'h00);
    send_write(24'hFFFFFF, 8'hA5);                // outside both regions
    send_write(100, 8'h5A);                       // in the hole
    send_write(61, 8'hC0);
    send_write(62, 8'hDE);
    send_write(159, 8'h80);
    send_search(0, 64'hFF, 1, 1'b0, 1'b0);
    send_search(0, 64'hFF, 0, 1'b0, 1'b0);        // zero length
    send_search(0, '1, 15, 1'b0, 1'b1);           // length saturates to eight
    send_search(24'hFFFFFF, 64'hFF, 1, 1'b1, 1'b0);  // starts past the ROM end
    send_search(100, 64'h80, 1, 1'b0, 1'b0);      // hole, upward hop
    send_search(150, 64'hFF, 1, 1'b1, 1'b0);      // downward hop into RAM
    send_search(1, 64'hC0, 1, 1'b0, 1'b1);        // odd hits skipped in word mode
    send_search(40, 64'h1100DEC0, 4, 1'b0, 1'b0); // would straddle RAM end and ROM
    send_search(60, 64'h00DEC0, 3, 1'b0, 1'b0);   // ends exactly at ram_top
    send_search(150, 64'h4280, 2, 1'b0, 1'b0);    // first byte at ROM end, no fit
    send_search(0, 64'h1234, 2, 1'b1, 1'b0);      // wraps below zero
    set_windows(0, 170, 0, 170);
    random_items(220);

    // Overlapping regions: low part of the ROM window is shadowed by RAM.
    set_config(64, 32, 96);
    fill(0, 96);
    set_windows(0, 100, 0, 100);
    random_items(160);

    // No RAM at all: a downward hop over the hole wraps below zero.
    set_config(0, 16, 64);
    fill(0, 64);
    set_windows(0, 72, 0, 72);
    send_search(40, 64'h0123456789ABCDEF, 8, 1'b1, 1'b0);
    random_items(120);

    // RAM window runs past the physical store; that tail reads as zero.
    set_config(RAM_SIZE + 32, RAM_SIZE + 64, RAM_SIZE + 96);
    fill(RAM_SIZE - 48, RAM_SIZE + 32);
    fill(RAM_SIZE + 64, RAM_SIZE + 96);
    set_windows(RAM_SIZE - 48, RAM_SIZE + 104, RAM_SIZE - 48, RAM_SIZE + 104);
    send_search(RAM_SIZE, 64'h0, 4, 1'b0, 1'b0);
    random_items(120);

    // Register maxima: all of the address space is RAM; scans stop past 24 bits.
    set_config(25'h1000000, 24'hFFFFFF, 25'h1000000);
    fill(24'hFFFFE0, 25'h1000000);
    set_windows(0, 72, 24'hFFFFC0, 24'hFFFFFF);
    random_items(110);

    // ROM window past the physical store, ending at the top of the address space.
    rb_far = 25'h1000000 - ROM_SIZE - 32;
    set_config(32, rb_far, 25'h1000000);
    fill(rb_far + ROM_SIZE - 48, 25'h1000000);
    set_windows(24'hFFFFB0, 24'hFFFFFF, 0, 40);
    send_search(24'hFFFFF8, 64'h01, 1, 1'b0, 1'b0);
    random_items(120);

    // Empty ROM window at zero, full rate with no gaps on either side.
    idle_enabled = 1'b0;
    set_config(32, 0, 0);
    set_windows(0, 48, 0, 48);
    random_items(100);

    wait_results_done();
    repeat (16) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("memory_byte_pattern_search regression: pass");
    end else begin
      $display("memory_byte_pattern_search regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/mbps_pkg.sv
rtl/mbps_ctrl.sv
rtl/mbps_dp.sv
rtl/memory_byte_pattern_search.sv
dv/tb.sv
